// File: rtl/core/drcc_pkg.sv
// Package for the dual-range coulomb counter: widths, fixed-point format,
// command and register codes, and configuration reset values.
// No dependencies.
package drcc_pkg;

    // Fixed-point format of the state of charge.
    localparam int FRAC_BITS = 32;
    localparam int CHARGE_INT_W = 10;
    localparam int CHARGE_W = FRAC_BITS + CHARGE_INT_W;

    // Field and tally widths.
    localparam int ADC_W = 12;
    localparam int COEF_W = 32;
    localparam int SUM_W = 28;
    localparam int COUNT_W = 16;
    localparam int SAVE_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 3;

    // Product and update arithmetic widths.
    localparam int GAIN_PROD_W = COEF_W + SUM_W;
    localparam int OFS_PROD_W = COEF_W + COUNT_W;
    localparam int DROP_W = GAIN_PROD_W + 1;
    localparam int CREDIT_W = OFS_PROD_W + 1;
    localparam int NET_W = DROP_W + 2;
    localparam int VAL_W = NET_W + 1;

    // Limits.
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [CHARGE_INT_W-1:0] CHARGE_FULL = CHARGE_INT_W'(1000);
    localparam logic [CHARGE_W-1:0] CHARGE_FULL_FIXED =
        {CHARGE_FULL, {FRAC_BITS{1'b0}}};
    localparam logic [SAVE_W-1:0] SAVE_AFTER = SAVE_W'(20);

    // Cycles for the product and net-charge registers to follow a change.
    localparam int FILL_W = 2;
    localparam logic [FILL_W-1:0] PIPE_FILL = FILL_W'(2);

    // Configuration reset values.
    localparam logic [ADC_W-1:0] THRESHOLD_RST = ADC_W'(3200);
    localparam logic [COEF_W-1:0] LOW_GAIN_RST = COEF_W'(87370);
    localparam logic [COEF_W-1:0] LOW_OFFSET_RST = COEF_W'(179199000);
    localparam logic [COEF_W-1:0] HIGH_GAIN_RST = COEF_W'(583200);
    localparam logic [COEF_W-1:0] HIGH_OFFSET_RST = COEF_W'(1196148000);
    localparam logic [CHARGE_INT_W-1:0] START_CHARGE_RST = CHARGE_INT_W'(1000);

    // Commands carried by an input item.
    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_UPDATE  = 2'd1,
        CMD_RESTORE = 2'd2
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESHOLD    = 3'd0,
        REG_LOW_GAIN     = 3'd1,
        REG_LOW_OFFSET   = 3'd2,
        REG_HIGH_GAIN    = 3'd3,
        REG_HIGH_OFFSET  = 3'd4,
        REG_START_CHARGE = 3'd5
    } reg_index_t;

endpackage

// File: rtl/core/dual_range_coulomb_counter.sv
// Top level of the dual-range coulomb counter: tallies, product registers,
// charge update and the result register.
// Depends on drcc_pkg.
//
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   cmd, low_sample, high_sample
// out       output     out_valid/out_stall charge_tenths, save_now, used_high
// cfg       input      cfg_write           cfg_index, cfg_data
//
// An item moves from the input register to the result register, and one
// transfer per cycle is sustained for samples and restores while out_stall is low.
// The update products are registered from the tallies and then summed into a
// registered net charge, so an update waits until both have followed the last
// tally change or configuration write.
// rst_n is asynchronous and active low; it loads the configuration defaults.
// A stalled result holds the next item in the input register.
module dual_range_coulomb_counter
    import drcc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                cmd,
    input  logic [ADC_W-1:0]          low_sample,
    input  logic [ADC_W-1:0]          high_sample,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [CHARGE_INT_W-1:0]   charge_tenths,
    output logic                      save_now,
    output logic                      used_high,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [ADC_W-1:0]        threshold_reg;
    logic [COEF_W-1:0]       low_gain_reg;
    logic [COEF_W-1:0]       low_offset_reg;
    logic [COEF_W-1:0]       high_gain_reg;
    logic [COEF_W-1:0]       high_offset_reg;
    logic [CHARGE_INT_W-1:0] start_charge_reg;

    // Input register.
    logic                    in_valid_reg;
    logic [1:0]              cmd_reg;
    logic [ADC_W-1:0]        low_reg;
    logic [ADC_W-1:0]        high_reg;

    // Block state.
    logic [CHARGE_W-1:0]     charge_reg;
    logic [CHARGE_W-1:0]     charge_next;
    logic [SUM_W-1:0]        low_sum_reg;
    logic [SUM_W-1:0]        low_sum_next;
    logic [SUM_W-1:0]        high_sum_reg;
    logic [SUM_W-1:0]        high_sum_next;
    logic [COUNT_W-1:0]      low_count_reg;
    logic [COUNT_W-1:0]      low_count_next;
    logic [COUNT_W-1:0]      high_count_reg;
    logic [COUNT_W-1:0]      high_count_next;
    logic [SAVE_W-1:0]       save_cnt_reg;
    logic [SAVE_W-1:0]       save_cnt_next;
    logic [FILL_W-1:0]       fill_reg;

    // Product and net-charge registers.
    logic [GAIN_PROD_W-1:0]  low_drop_reg;
    logic [GAIN_PROD_W-1:0]  high_drop_reg;
    logic [OFS_PROD_W-1:0]   low_credit_reg;
    logic [OFS_PROD_W-1:0]   high_credit_reg;
    logic [NET_W-1:0]        net_reg;
    logic [NET_W-1:0]        net_next;

    // Result register.
    logic                    out_valid_reg;
    logic [CHARGE_INT_W-1:0] charge_out_reg;
    logic                    save_out_reg;
    logic                    high_out_reg;
    logic                    save_flag;
    logic                    high_flag;

    // Handshake and datapath helpers.
    logic                    in_xfer;
    logic                    out_xfer;
    logic                    out_free;
    logic                    update_wait;
    logic                    advance;
    logic [SUM_W:0]          low_add;
    logic [SUM_W:0]          high_add;
    logic [DROP_W-1:0]       drop_sum;
    logic [CREDIT_W-1:0]     credit_sum;
    logic [VAL_W-1:0]        upd_val;
    logic [CHARGE_W-1:0]     upd_charge;
    logic [CHARGE_INT_W-1:0] restore_int;

    // Handshake control: an update waits for fresh net-charge registers.
    assign in_xfer     = in_valid && !in_stall;
    assign out_xfer    = out_valid_reg && !out_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign update_wait = (cmd_reg == CMD_UPDATE) && (fill_reg != '0);
    assign advance     = in_valid_reg && out_free && !update_wait;
    assign in_stall    = in_valid_reg && !advance;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RST;
            low_gain_reg     <= LOW_GAIN_RST;
            low_offset_reg   <= LOW_OFFSET_RST;
            high_gain_reg    <= HIGH_GAIN_RST;
            high_offset_reg  <= HIGH_OFFSET_RST;
            start_charge_reg <= START_CHARGE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_THRESHOLD:    threshold_reg    <= cfg_data[ADC_W-1:0];
                REG_LOW_GAIN:     low_gain_reg     <= cfg_data[COEF_W-1:0];
                REG_LOW_OFFSET:   low_offset_reg   <= cfg_data[COEF_W-1:0];
                REG_HIGH_GAIN:    high_gain_reg    <= cfg_data[COEF_W-1:0];
                REG_HIGH_OFFSET:  high_offset_reg  <= cfg_data[COEF_W-1:0];
                REG_START_CHARGE: start_charge_reg <= cfg_data[CHARGE_INT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input register: valid flag under reset, payload loaded on a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg  <= cmd;
            low_reg  <= low_sample;
            high_reg <= high_sample;
        end
    end

    // Products of the current tallies, then their net effect on the charge.
    assign drop_sum   = DROP_W'(low_drop_reg) + DROP_W'(high_drop_reg);
    assign credit_sum = CREDIT_W'(low_credit_reg) + CREDIT_W'(high_credit_reg);
    assign net_next   = NET_W'(credit_sum) - NET_W'(drop_sum);

    always_ff @(posedge clk)
    begin
        low_drop_reg    <= GAIN_PROD_W'(low_gain_reg) * GAIN_PROD_W'(low_sum_reg);
        high_drop_reg   <= GAIN_PROD_W'(high_gain_reg) * GAIN_PROD_W'(high_sum_reg);
        low_credit_reg  <= OFS_PROD_W'(low_offset_reg) * OFS_PROD_W'(low_count_reg);
        high_credit_reg <= OFS_PROD_W'(high_offset_reg) * OFS_PROD_W'(high_count_reg);
        net_reg         <= net_next;
    end

    // Saturating tally sums.
    assign low_add  = {1'b0, low_sum_reg} + (SUM_W + 1)'(low_reg);
    assign high_add = {1'b0, high_sum_reg} + (SUM_W + 1)'(high_reg);

    // Charge after an update, clamped to the empty and full marks.
    assign upd_val = VAL_W'(charge_reg) + {net_reg[NET_W-1], net_reg};

    always_comb
    begin
        if (upd_val[VAL_W-1])
        begin
            upd_charge = '0;
        end
        else if (upd_val > VAL_W'(CHARGE_FULL_FIXED))
        begin
            upd_charge = CHARGE_FULL_FIXED;
        end
        else
        begin
            upd_charge = upd_val[CHARGE_W-1:0];
        end
    end

    assign restore_int = (start_charge_reg > CHARGE_FULL) ? CHARGE_FULL
                                                          : start_charge_reg;

    // Next state and result flags for the item in the input register.
    always_comb
    begin
        charge_next     = charge_reg;
        low_sum_next    = low_sum_reg;
        high_sum_next   = high_sum_reg;
        low_count_next  = low_count_reg;
        high_count_next = high_count_reg;
        save_cnt_next   = save_cnt_reg;
        save_flag       = 1'b0;
        high_flag       = 1'b0;
        case (cmd_reg)
            CMD_SAMPLE:
            begin
                if (low_reg < threshold_reg)
                begin
                    low_sum_next   = low_add[SUM_W] ? SUM_MAX : low_add[SUM_W-1:0];
                    low_count_next = (low_count_reg == COUNT_MAX) ? COUNT_MAX
                                                                  : low_count_reg + 1'b1;
                end
                else
                begin
                    high_sum_next   = high_add[SUM_W] ? SUM_MAX : high_add[SUM_W-1:0];
                    high_count_next = (high_count_reg == COUNT_MAX) ? COUNT_MAX
                                                                    : high_count_reg + 1'b1;
                    high_flag       = 1'b1;
                end
            end
            CMD_UPDATE:
            begin
                charge_next     = upd_charge;
                low_sum_next    = '0;
                high_sum_next   = '0;
                low_count_next  = '0;
                high_count_next = '0;
                if (save_cnt_reg >= SAVE_AFTER)
                begin
                    save_cnt_next = '0;
                    save_flag     = 1'b1;
                end
                else
                begin
                    save_cnt_next = save_cnt_reg + 1'b1;
                end
            end
            CMD_RESTORE:
            begin
                charge_next = {restore_int, {FRAC_BITS{1'b0}}};
            end
            default:
            begin
                charge_next = charge_reg;
            end
        endcase
    end

    // State registers advance with each item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_reg     <= CHARGE_FULL_FIXED;
            low_sum_reg    <= '0;
            high_sum_reg   <= '0;
            low_count_reg  <= '0;
            high_count_reg <= '0;
            save_cnt_reg   <= '0;
        end
        else if (advance)
        begin
            charge_reg     <= charge_next;
            low_sum_reg    <= low_sum_next;
            high_sum_reg   <= high_sum_next;
            low_count_reg  <= low_count_next;
            high_count_reg <= high_count_next;
            save_cnt_reg   <= save_cnt_next;
        end
    end

    // Fill counter: cycles until the net-charge register matches the tallies and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= PIPE_FILL;
        end
        else if (cfg_write || (advance && (cmd_reg == CMD_SAMPLE || cmd_reg == CMD_UPDATE)))
        begin
            fill_reg <= PIPE_FILL;
        end
        else if (fill_reg != '0)
        begin
            fill_reg <= fill_reg - 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            charge_out_reg <= charge_next[FRAC_BITS +: CHARGE_INT_W];
            save_out_reg   <= save_flag;
            high_out_reg   <= high_flag;
        end
    end

    assign out_valid     = out_valid_reg;
    assign charge_tenths = charge_out_reg;
    assign save_now      = save_out_reg;
    assign used_high     = high_out_reg;

    // The charge never leaves the range from empty to full.
    assert property (@(posedge clk) disable iff (!rst_n)
        charge_reg <= CHARGE_FULL_FIXED)
        else $error("charge above full");

    // The save counter restarts before it passes the save point.
    assert property (@(posedge clk) disable iff (!rst_n)
        save_cnt_reg <= SAVE_AFTER)
        else $error("save counter out of range");

    // A result is never both a save strobe and a high-range sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(save_out_reg && high_out_reg))
        else $error("save and high-range flags together");

    // An update only goes ahead once the net-charge register is current.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == CMD_UPDATE) |-> $past(fill_reg) <= FILL_W'(1))
        else $error("update used stale products");

endmodule
